// ===== rtl/lprt_pkg.sv =====
// Shared types, constants and helpers for the longest-prefix route table.
package lprt_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [5:0]  MAX_BITS        = 6'd32;
  localparam logic [7:0]  METRIC_INFINITY = 8'd16;
  localparam logic [3:0]  TUNNEL_RESET    = 4'd15;
  localparam logic [31:0] ADDR_ONES       = 32'hFFFF_FFFF;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_DROP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROUTE = 2'd1,
    ST_REJECTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [5:0]  bits;
    logic [31:0] target;
  } key_t;

  typedef struct packed {
    logic [31:0] gateway;
    logic [3:0]  iface;
    logic [7:0]  metric;
    logic        priv;
  } route_t;

  // Table write request from the sequencer
  typedef struct packed {
    logic   wr_en;
    logic   clr_en;
    idx_t   idx;
    key_t   key;
    route_t data;
  } wr_t;

  // Per-entry compare result
  typedef struct packed {
    logic lk_hit;
    logic exact_hit;
  } cmp_t;

  // Network mask for a prefix length of 0 to 32
  function automatic logic [31:0] prefix_mask(logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else begin
      m = ADDR_ONES << (MAX_BITS - len);
    end
    return m;
  endfunction

endpackage

// ===== rtl/lprt_store.sv =====
// Route entry storage: key and data memories with registered read, valid flags.
module lprt_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lprt_pkg::idx_t  rd_idx_i,
  input  lprt_pkg::wr_t   wr_i,
  output lprt_pkg::key_t  rd_key_o,
  output lprt_pkg::route_t rd_data_o,
  output logic            rd_valid_o
);
  import lprt_pkg::*;

  key_t   key_mem  [ENTRIES];
  route_t data_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  key_t   rd_key_q;
  route_t rd_data_q;
  logic   rd_valid_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      key_mem[wr_i.idx]  <= wr_i.key;
      data_mem[wr_i.idx] <= wr_i.data;
    end
    rd_key_q  <= key_mem[rd_idx_i];
    rd_data_q <= data_mem[rd_idx_i];
  end

  // Valid flags: set on add, drop on remove
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.wr_en) begin
        valid_q[wr_i.idx] <= 1'b1;
      end else if (wr_i.clr_en) begin
        valid_q[wr_i.idx] <= 1'b0;
      end
      rd_valid_q <= valid_q[rd_idx_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

// ===== rtl/lprt_cmp.sv =====
// Shared compare unit: tests one stored entry against the current request.
module lprt_cmp (
  input  lprt_pkg::key_t   key_i,
  input  lprt_pkg::route_t data_i,
  input  logic             valid_i,
  input  logic [31:0]      addr_i,
  input  logic [5:0]       bits_i,
  input  logic [31:0]      target_i,
  input  logic [3:0]       tunnel_i,
  output lprt_pkg::cmp_t   cmp_o
);
  import lprt_pkg::*;

  logic len_ok;
  logic pfx_ok;
  logic tun_skip;

  // Lookup candidate: prefix covers the address, not a looping tunnel route
  assign len_ok   = (key_i.bits != 6'd0) && (key_i.bits <= MAX_BITS);
  assign pfx_ok   = (addr_i & prefix_mask(key_i.bits)) == key_i.target;
  assign tun_skip = (data_i.iface == tunnel_i) && (data_i.gateway == addr_i);

  assign cmp_o.lk_hit    = valid_i && len_ok && pfx_ok && !tun_skip;
  assign cmp_o.exact_hit = valid_i && (key_i.bits == bits_i) && (key_i.target == target_i);

endmodule

// ===== rtl/longest_prefix_route_table_top.sv =====
// Longest-prefix IPv4 route table: request sequencer, scan state and result register.
// Each request is captured, scanned across all entries and then decided into the result register.
// One transaction at a time: a new request is taken only when idle; every request scans all
// entries once through the single read port of the entry memories and one compare unit.
// Reset clears all valid flags, disables the default route (metric 16) and sets the
// tunnel interface to 15; no clearing pass is needed.
module longest_prefix_route_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [5:0]  prefix_len_i,
  input  logic [31:0] gateway_in_i,
  input  logic [3:0]  iface_in_i,
  input  logic [7:0]  metric_in_i,
  input  logic        private_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] next_hop_o,
  output logic [31:0] route_gateway_o,
  output logic [3:0]  route_iface_o,
  output logic [7:0]  route_metric_o,
  output logic [5:0]  route_prefix_len_o,
  output logic        route_private_o,
  output logic        used_default_o
);
  import lprt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e       state_q;
  logic [CNT_W-1:0] cnt_q;
  idx_t         cmp_idx_q;
  logic         cmp_vld_q;
  logic [3:0]   tunnel_q;

  // Captured request
  logic [1:0]   op_q;
  logic [31:0]  addr_q;
  logic [5:0]   bits_q;
  logic [31:0]  target_q;
  route_t       nd_q;

  // Scan results
  logic         best_found_q;
  logic [5:0]   best_bits_q;
  route_t       best_data_q;
  logic         exact_found_q;
  idx_t         exact_idx_q;
  logic         free_found_q;
  idx_t         free_idx_q;

  // Default route
  logic         def_valid_q;
  route_t       def_data_q;

  // Result register
  logic         out_valid_q;
  logic [1:0]   status_q;
  logic [31:0]  next_hop_q;
  route_t       res_route_q;
  logic [5:0]   res_bits_q;
  logic         used_default_q;

  key_t         rd_key;
  route_t       rd_data;
  logic         rd_valid;
  cmp_t         cmp;
  wr_t          wr;

  logic         in_fire;
  logic         fin_go;
  logic [5:0]   in_bits;
  logic         add_reject;
  logic [1:0]   status_d;
  logic [31:0]  next_hop_d;
  route_t       res_route_d;
  logic [5:0]   res_bits_d;
  logic         used_default_d;
  logic         def_valid_d;
  logic         def_load_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_go     = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign in_bits    = (prefix_len_i > MAX_BITS) ? MAX_BITS : prefix_len_i;
  assign add_reject = (nd_q.iface == tunnel_q) && (nd_q.gateway == 32'd0);

  lprt_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (cnt_q[IDX_W-1:0]),
    .wr_i       (wr),
    .rd_key_o   (rd_key),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid)
  );

  lprt_cmp u_cmp (
    .key_i    (rd_key),
    .data_i   (rd_data),
    .valid_i  (rd_valid),
    .addr_i   (addr_q),
    .bits_i   (bits_q),
    .target_i (target_q),
    .tunnel_i (tunnel_q),
    .cmp_o    (cmp)
  );

  // Decide the outcome and the table update at the end of the scan
  always_comb begin
    status_d       = ST_OK;
    next_hop_d     = 32'd0;
    res_route_d    = '0;
    res_bits_d     = 6'd0;
    used_default_d = 1'b0;
    def_valid_d    = def_valid_q;
    def_load_d     = 1'b0;
    wr             = '0;
    wr.key.bits    = bits_q;
    wr.key.target  = target_q;
    wr.data        = nd_q;
    wr.idx         = exact_found_q ? exact_idx_q : free_idx_q;
    case (op_q)
      OP_LOOKUP: begin
        if (best_found_q) begin
          res_route_d = best_data_q;
          res_bits_d  = best_bits_q;
          next_hop_d  = (best_data_q.gateway != 32'd0) ? best_data_q.gateway : addr_q;
        end else if (def_valid_q) begin
          res_route_d    = def_data_q;
          used_default_d = 1'b1;
          next_hop_d     = (def_data_q.gateway != 32'd0) ? def_data_q.gateway : addr_q;
        end else begin
          status_d = ST_NO_ROUTE;
        end
      end
      OP_ADD: begin
        if (add_reject) begin
          status_d = ST_REJECTED;
        end else if (bits_q == 6'd0) begin
          def_load_d  = 1'b1;
          def_valid_d = 1'b1;
          res_route_d = nd_q;
        end else if (exact_found_q || free_found_q) begin
          wr.wr_en    = fin_go;
          res_route_d = nd_q;
          res_bits_d  = bits_q;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_DROP: begin
        if (bits_q == 6'd0) begin
          def_valid_d = 1'b0;
        end else if (exact_found_q) begin
          wr.clr_en = fin_go;
          wr.idx    = exact_idx_q;
        end else begin
          status_d = ST_NO_ROUTE;
        end
      end
      default: begin
        status_d = ST_REJECTED;
      end
    endcase
  end

  // Tunnel interface register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tunnel_q <= TUNNEL_RESET;
    end else if (cfg_we_i) begin
      tunnel_q <= cfg_wdata_i;
    end
  end

  // Sequencer: capture, scan every entry, decide, hold the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cnt_q          <= '0;
      cmp_idx_q      <= '0;
      cmp_vld_q      <= 1'b0;
      op_q           <= '0;
      best_found_q   <= 1'b0;
      best_bits_q    <= '0;
      exact_found_q  <= 1'b0;
      exact_idx_q    <= '0;
      free_found_q   <= 1'b0;
      free_idx_q     <= '0;
      def_valid_q    <= 1'b0;
      def_data_q     <= '{gateway: 32'd0, iface: 4'd0, metric: METRIC_INFINITY, priv: 1'b0};
      out_valid_q    <= 1'b0;
      status_q       <= '0;
      next_hop_q     <= '0;
      res_route_q    <= '0;
      res_bits_q     <= '0;
      used_default_q <= 1'b0;
    end else begin
      // Drop a result once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q          <= operation_i;
            addr_q        <= address_i;
            bits_q        <= in_bits;
            target_q      <= address_i & prefix_mask(in_bits);
            nd_q          <= '{gateway: gateway_in_i, iface: iface_in_i,
                               metric: metric_in_i, priv: private_in_i};
            best_found_q  <= 1'b0;
            best_bits_q   <= '0;
            exact_found_q <= 1'b0;
            free_found_q  <= 1'b0;
            cnt_q         <= '0;
            cmp_vld_q     <= 1'b0;
            state_q       <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Advance the read address, compare the entry read last cycle
          cmp_vld_q <= (cnt_q < CNT_W'(ENTRIES));
          cmp_idx_q <= cnt_q[IDX_W-1:0];
          if (cnt_q == CNT_W'(ENTRIES)) begin
            state_q <= S_FINISH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (cmp_vld_q) begin
            if (cmp.lk_hit && (rd_key.bits > best_bits_q)) begin
              best_found_q <= 1'b1;
              best_bits_q  <= rd_key.bits;
              best_data_q  <= rd_data;
            end
            if (cmp.exact_hit && !exact_found_q) begin
              exact_found_q <= 1'b1;
              exact_idx_q   <= cmp_idx_q;
            end
            if (!rd_valid && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= cmp_idx_q;
            end
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            out_valid_q    <= 1'b1;
            status_q       <= status_d;
            next_hop_q     <= next_hop_d;
            res_route_q    <= res_route_d;
            res_bits_q     <= res_bits_d;
            used_default_q <= used_default_d;
            def_valid_q    <= def_valid_d;
            if (def_load_d) begin
              def_data_q <= nd_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign next_hop_o         = next_hop_q;
  assign route_gateway_o    = res_route_q.gateway;
  assign route_iface_o      = res_route_q.iface;
  assign route_metric_o     = res_route_q.metric;
  assign route_prefix_len_o = res_bits_q;
  assign route_private_o    = res_route_q.priv;
  assign used_default_o     = used_default_q;

endmodule

// ===== rtl/lprt_checker.sv =====
// Port-level checker for the route table top level, with its bind statement.
module lprt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [3:0]  cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  operation_i,
  input logic [31:0] address_i,
  input logic [5:0]  prefix_len_i,
  input logic [31:0] gateway_in_i,
  input logic [3:0]  iface_in_i,
  input logic [7:0]  metric_in_i,
  input logic        private_in_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] next_hop_o,
  input logic [31:0] route_gateway_o,
  input logic [3:0]  route_iface_o,
  input logic [7:0]  route_metric_o,
  input logic [5:0]  route_prefix_len_o,
  input logic        route_private_o,
  input logic        used_default_o
);
  import lprt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(next_hop_o))
    else $error("result changed while stalled");

  // One transaction at a time: busy after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !in_ready_o)
    else $error("accepted a second transaction during a scan");

  // A failed request carries no route
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      next_hop_o == 32'd0 && route_gateway_o == 32'd0 && route_metric_o == 8'd0 &&
      route_prefix_len_o == 6'd0 && !used_default_o && !route_private_o)
    else $error("failed request returned route fields");

  // Default answers are successful and prefix-less
  a_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && used_default_o |-> status_o == ST_OK && route_prefix_len_o == 6'd0)
    else $error("default route result malformed");

  // Prefix length never exceeds the address width
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> route_prefix_len_o <= MAX_BITS)
    else $error("prefix length above 32");

endmodule

bind longest_prefix_route_table_top lprt_checker u_lprt_checker (.*);
